>>> src/polymul_pkg.sv
`timescale 1ns / 1ps

package polymul_pkg;

  // Storage sizing for each operand.
  localparam int MAX_TERMS  = 32;
  localparam int IDX_W      = $clog2(MAX_TERMS);
  localparam int CNT_W      = $clog2(MAX_TERMS + 1);

  // Coefficient and result formats.
  localparam int COEFF_IN_W = 16;
  localparam int COEFF_BITS = 16;
  localparam int MUL_W      = 2 * COEFF_BITS;
  localparam int PROD_W     = 37;
  localparam int DEG_W      = 6;

  // Operand select codes.
  localparam logic OP_FIRST  = 1'b0;
  localparam logic OP_SECOND = 1'b1;

endpackage

>>> src/polynomial_multiplier.sv
`timescale 1ns / 1ps

// Polynomial multiplier.
// Input channel (in_valid_i / in_ready_o) takes one coefficient word per cycle
// while loading: req_type_i picks the operand, coeff_i is signed Q8.8, last_i
// closes that operand. Coefficients past MAX_TERMS are dropped; words for an
// operand that is already closed are dropped while the other one is still open.
// Once both operands are closed the block stops taking words and sends the
// product, one word per degree from 0 up, on the output channel
// (out_valid_o / out_ready_i). product_coeff_o is signed Q21.16, degree_index_o
// is the degree and last_out_o flags the highest degree.
// One multiplier is shared: each product coefficient passes a setup step, one
// issue step per term pair, memory read, multiply and accumulate drain, and
// the output register.
// The next degree starts only after the output word is taken, so a stalled
// receiver simply holds the block. After the last word both counts clear and
// the input channel opens again on the next cycle.
// Reset empties both operands and drops any pending result; the coefficient
// memories are not cleared, since only written entries are ever read.
module polynomial_multiplier (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic                                  req_type_i,
  input  logic signed [polymul_pkg::COEFF_IN_W-1:0] coeff_i,
  input  logic                                  last_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [polymul_pkg::PROD_W-1:0] product_coeff_o,
  output logic        [polymul_pkg::DEG_W-1:0]  degree_index_o,
  output logic                                  last_out_o
);
  import polymul_pkg::*;

  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_ISSUE = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0]                    state_q, state_d;
  logic [CNT_W-1:0]              cnt_a_q, cnt_a_d, cnt_b_q, cnt_b_d;
  logic                          done_a_q, done_a_d, done_b_q, done_b_d;
  logic [DEG_W-1:0]              deg_q, deg_d;
  logic [IDX_W-1:0]              j_q, j_d, jend_q, jend_d;
  logic                          rd_v_q, mul_v_q;
  logic signed [COEFF_BITS-1:0]  rd_a_q, rd_b_q;
  logic signed [MUL_W-1:0]       mul_q;
  logic signed [PROD_W-1:0]      acc_q;
  logic                          out_valid_q;
  logic signed [PROD_W-1:0]      out_coeff_q;
  logic [DEG_W-1:0]              out_deg_q;
  logic                          out_last_q;

  logic signed [COEFF_BITS-1:0]  mem_a [MAX_TERMS];
  logic signed [COEFF_BITS-1:0]  mem_b [MAX_TERMS];

  logic                          in_acc, out_acc;
  logic                          wr_a, wr_b;
  logic                          issue;
  logic [IDX_W-1:0]              idx_b;
  logic [DEG_W:0]                deg_top;
  logic                          deg_is_top;
  logic [DEG_W-1:0]              jlo_full, jhi_full;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_q && out_ready_i;
  assign issue   = (state_q == S_ISSUE);

  // Highest product degree is first_count + second_count - 2.
  assign deg_top    = (DEG_W+1)'(cnt_a_q) + (DEG_W+1)'(cnt_b_q) - (DEG_W+1)'(2);
  assign deg_is_top = ({1'b0, deg_q} == deg_top);

  // Term range for the current degree: j from max(0, d-sc+1) to min(d, fc-1).
  always_comb begin
    if (DEG_W'(deg_q) >= DEG_W'(cnt_b_q)) begin
      jlo_full = deg_q - DEG_W'(cnt_b_q) + DEG_W'(1);
    end else begin
      jlo_full = '0;
    end
    if (deg_q < DEG_W'(cnt_a_q)) begin
      jhi_full = deg_q;
    end else begin
      jhi_full = DEG_W'(cnt_a_q) - DEG_W'(1);
    end
  end

  assign idx_b = IDX_W'(deg_q - DEG_W'(j_q));

  // Operand loading: a word is stored while its operand is open and not full.
  assign wr_a = in_acc && (req_type_i == OP_FIRST) && !done_a_q
                && (cnt_a_q < CNT_W'(MAX_TERMS));
  assign wr_b = in_acc && (req_type_i == OP_SECOND) && !done_b_q
                && (cnt_b_q < CNT_W'(MAX_TERMS));

  // Sequencer.
  always_comb begin
    state_d  = state_q;
    cnt_a_d  = cnt_a_q;
    cnt_b_d  = cnt_b_q;
    done_a_d = done_a_q;
    done_b_d = done_b_q;
    deg_d    = deg_q;
    j_d      = j_q;
    jend_d   = jend_q;
    case (state_q)
      S_LOAD: begin
        if (in_acc) begin
          if (req_type_i == OP_FIRST) begin
            if (wr_a) begin
              cnt_a_d = cnt_a_q + CNT_W'(1);
            end
            if (!done_a_q && last_i) begin
              done_a_d = 1'b1;
            end
          end else begin
            if (wr_b) begin
              cnt_b_d = cnt_b_q + CNT_W'(1);
            end
            if (!done_b_q && last_i) begin
              done_b_d = 1'b1;
            end
          end
          if (done_a_d && done_b_d) begin
            deg_d   = '0;
            state_d = S_START;
          end
        end
      end
      S_START: begin
        j_d     = IDX_W'(jlo_full);
        jend_d  = IDX_W'(jhi_full);
        state_d = S_ISSUE;
      end
      S_ISSUE: begin
        if (j_q == jend_q) begin
          state_d = S_DRAIN;
        end else begin
          j_d = j_q + IDX_W'(1);
        end
      end
      S_DRAIN: begin
        if (!rd_v_q && !mul_v_q) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_acc) begin
          if (out_last_q) begin
            cnt_a_d  = '0;
            cnt_b_d  = '0;
            done_a_d = 1'b0;
            done_b_d = 1'b0;
            state_d  = S_LOAD;
          end else begin
            deg_d   = deg_q + DEG_W'(1);
            state_d = S_START;
          end
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_LOAD;
      cnt_a_q  <= '0;
      cnt_b_q  <= '0;
      done_a_q <= 1'b0;
      done_b_q <= 1'b0;
      deg_q    <= '0;
      j_q      <= '0;
      jend_q   <= '0;
    end else begin
      state_q  <= state_d;
      cnt_a_q  <= cnt_a_d;
      cnt_b_q  <= cnt_b_d;
      done_a_q <= done_a_d;
      done_b_q <= done_b_d;
      deg_q    <= deg_d;
      j_q      <= j_d;
      jend_q   <= jend_d;
    end
  end

  // Coefficient memories: one write port, one registered read port each.
  always_ff @(posedge clk_i) begin
    if (wr_a) begin
      mem_a[cnt_a_q[IDX_W-1:0]] <= coeff_i[COEFF_BITS-1:0];
    end
    if (wr_b) begin
      mem_b[cnt_b_q[IDX_W-1:0]] <= coeff_i[COEFF_BITS-1:0];
    end
    rd_a_q <= mem_a[j_q];
    rd_b_q <= mem_b[idx_b];
  end

  // Shared multiply-accumulate pipeline valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q  <= 1'b0;
      mul_v_q <= 1'b0;
    end else begin
      rd_v_q  <= issue;
      mul_v_q <= rd_v_q;
    end
  end

  // Multiply, then accumulate; the accumulator clears at the start of a degree.
  always_ff @(posedge clk_i) begin
    mul_q <= rd_a_q * rd_b_q;
    if (state_q == S_START) begin
      acc_q <= '0;
    end else if (mul_v_q) begin
      acc_q <= acc_q + PROD_W'(mul_q);
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_DRAIN && state_d == S_OUT) begin
      out_valid_q <= 1'b1;
    end else if (out_acc) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_DRAIN && state_d == S_OUT) begin
      out_coeff_q <= acc_q;
      out_deg_q   <= deg_q;
      out_last_q  <= deg_is_top;
    end
  end

  assign in_ready_o      = (state_q == S_LOAD);
  assign out_valid_o     = out_valid_q;
  assign product_coeff_o = out_coeff_q;
  assign degree_index_o  = out_deg_q;
  assign last_out_o      = out_last_q;

  // The block never takes a word while a result is pending.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while a result is pending");

  // The multiply pipeline is empty whenever a result is shown or loading runs.
  a_pipe_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT || state_q == S_LOAD) |-> (!rd_v_q && !mul_v_q))
    else $error("multiply pipeline busy outside computation");

  // After the last product word both operands are empty and loading resumes.
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && out_last_q) |=> (in_ready_o && cnt_a_q == '0 && cnt_b_q == '0
                                 && !done_a_q && !done_b_q))
    else $error("operands not cleared after last product word");

  // The issue index never passes the end of the term range.
  a_issue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue |-> (j_q <= jend_q))
    else $error("term index beyond range");

endmodule
